// File: src/circular_indexed_deque_defines.svh
// Assertion macros shared by the circular indexed deque RTL.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef CIRCULAR_INDEXED_DEQUE_DEFINES_SVH
`define CIRCULAR_INDEXED_DEQUE_DEFINES_SVH

// Check a property at every rising clock edge outside reset.
`define CID_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define CID_ASSERT_NEVER(lbl, expr, msg) \
    `CID_ASSERT(lbl, !(expr), msg)

`endif

// File: src/cid_pkg.sv
// Shared types and codes for the circular indexed deque.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package cid_pkg;

    // Command codes
    localparam logic [1:0] CMD_GET = 2'd0;
    localparam logic [1:0] CMD_SET = 2'd1;
    localparam logic [1:0] CMD_INS = 2'd2;
    localparam logic [1:0] CMD_REM = 2'd3;

    // Status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_RANGE = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the request fields
        logic look;     // read the addressed entry
        logic load;     // keep the old entry, load the shift engine
        logic step;     // run one shift move
        logic fin;      // commit pointers, final write, post the result
    } ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic mv_done;  // no shift moves left to issue
    } sts_t;

endpackage

`default_nettype wire

// File: src/cid_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: src/cid_ctrl.sv
// Sequencing state machine of the circular indexed deque.
// Depends on cid_pkg and circular_indexed_deque_defines.svh.
`default_nettype none
`include "circular_indexed_deque_defines.svh"

module cid_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  cid_pkg::sts_t sts,
    output cid_pkg::ctl_t ctl
);

    import cid_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_DATA = 3'd2;
    localparam logic [2:0] S_MOVE = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Advance through look, data, move and finish for each request
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_LOOK;
                end
            end
            S_LOOK:
            begin
                ctl.look   = 1'b1;
                state_next = S_DATA;
            end
            S_DATA:
            begin
                ctl.load   = 1'b1;
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                ctl.step = 1'b1;
                if (sts.mv_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                ctl.fin    = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    `CID_ASSERT(a_accept_to_look, (state_reg == S_IDLE && start) |=> (state_reg == S_LOOK), "accepted request did not start a lookup")
    `CID_ASSERT(a_move_holds, (state_reg == S_MOVE && !sts.mv_done) |=> (state_reg == S_MOVE), "shift left before all moves were done")
    `CID_ASSERT(a_ctl_onehot, $onehot0({ctl.capture, ctl.look, ctl.load, ctl.step, ctl.fin}), "more than one datapath command at once")
    `CID_ASSERT(a_fin_to_idle, (state_reg == S_FIN) |=> (state_reg == S_IDLE), "finish did not return to idle")

endmodule

`default_nettype wire

// File: src/cid_datapath.sv
// Datapath of the circular indexed deque: request decode, ring pointers,
// shift engine and result registers. Depends on cid_pkg, cid_ram and
// circular_indexed_deque_defines.svh.
`default_nettype none
`include "circular_indexed_deque_defines.svh"

module cid_datapath #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cid_pkg::ctl_t                  ctl,
    output cid_pkg::sts_t                  sts,
    input  logic [1:0]                     cmd,
    input  logic [$clog2(DEPTH+1):0]       index,
    input  logic [VALUE_WIDTH-1:0]         value,
    output logic                           done,
    output logic [VALUE_WIDTH-1:0]         data_out,
    output logic [1:0]                     status,
    output logic [$clog2(DEPTH+1)-1:0]     count
);

    import cid_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);
    localparam int PW = CW + 1;

    localparam logic signed [PW+1:0] DEPTH_S  = (PW+2)'(DEPTH);
    localparam logic signed [PW-1:0] ZERO_S   = '0;
    localparam logic signed [PW-1:0] ONE_S    = PW'(1);
    localparam logic signed [PW-1:0] MINUS1_S = '1;

    localparam logic [2:0] KIND_ERR = 3'd0;
    localparam logic [2:0] KIND_GET = 3'd1;
    localparam logic [2:0] KIND_SET = 3'd2;
    localparam logic [2:0] KIND_INS = 3'd3;
    localparam logic [2:0] KIND_REM = 3'd4;

    // Physical slot of a logical position in -1..DEPTH
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] f,
                                           input logic signed [PW-1:0] pos);
        logic signed [PW+1:0] s;
        s = $signed({{(PW+2-AW){1'b0}}, f}) + $signed({{2{pos[PW-1]}}, pos});
        if (s < 0)
        begin
            s = s + DEPTH_S;
        end
        else if (s >= DEPTH_S)
        begin
            s = s - DEPTH_S;
        end
        return s[AW-1:0];
    endfunction

    // Request fields and results
    logic [1:0]              cmd_reg;
    logic signed [PW-1:0]    idx_reg;
    logic [VALUE_WIDTH-1:0]  val_reg;
    logic [VALUE_WIDTH-1:0]  old_reg;
    logic [VALUE_WIDTH-1:0]  data_out_reg;
    logic [1:0]              status_reg;
    logic                    done_reg;

    // Ring state
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic [AW-1:0]           front_reg;
    logic [AW-1:0]           front_next;

    // Shift engine
    logic signed [PW-1:0]    dst_reg;
    logic signed [PW-1:0]    dst_next;
    logic [CW-1:0]           cnt_reg;
    logic [CW-1:0]           cnt_next;
    logic                    step_dn_reg;
    logic                    step_dn_next;
    logic                    wr_pend_reg;
    logic                    wr_pend_next;
    logic [AW-1:0]           wr_addr_reg;
    logic signed [PW-1:0]    src_pos;

    // Decode
    logic signed [PW-1:0]    n_s;
    logic signed [PW-1:0]    half_s;
    logic signed [PW-1:0]    ipos;
    logic signed [PW-1:0]    dst0;
    logic signed [PW-1:0]    m0;
    logic                    step_dn0;
    logic                    in_rng;
    logic                    ins_rng;
    logic                    is_m1;
    logic                    is_n;
    logic                    full;
    logic                    ins_back;
    logic                    rem_back;
    logic                    front_side;
    logic [2:0]              kind;
    logic [1:0]              err_code;
    logic [AW-1:0]           fin_addr;

    // Memory port
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [VALUE_WIDTH-1:0]  ram_wdata;
    logic [AW-1:0]           ram_raddr;
    logic [VALUE_WIDTH-1:0]  ram_rdata;

    cid_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Classify the request against the current count
    always_comb
    begin
        n_s     = $signed({1'b0, count_reg});
        half_s  = $signed({2'b00, count_reg[CW-1:1]});
        in_rng  = !idx_reg[PW-1] && (idx_reg < n_s);
        ins_rng = !idx_reg[PW-1] && (idx_reg <= n_s);
        is_m1   = (idx_reg == MINUS1_S);
        is_n    = (idx_reg == n_s);
        full    = (count_reg == CW'(DEPTH));
        kind     = KIND_ERR;
        err_code = STS_RANGE;
        ipos     = idx_reg;
        case (cmd_reg)
            CMD_GET:
            begin
                if (in_rng)
                begin
                    kind = KIND_GET;
                end
            end
            CMD_SET:
            begin
                if (in_rng)
                begin
                    kind = KIND_SET;
                end
                else if (is_m1 || is_n)
                begin
                    ipos = is_m1 ? ZERO_S : n_s;
                    if (full)
                    begin
                        err_code = STS_FULL;
                    end
                    else
                    begin
                        kind = KIND_INS;
                    end
                end
            end
            CMD_INS:
            begin
                if (ins_rng)
                begin
                    if (full)
                    begin
                        err_code = STS_FULL;
                    end
                    else
                    begin
                        kind = KIND_INS;
                    end
                end
            end
            default:
            begin
                if (in_rng)
                begin
                    kind = KIND_REM;
                end
            end
        endcase
    end

    // Pick the shift side and the run of moves
    always_comb
    begin
        ins_back   = (ipos == n_s) || (ipos > half_s);
        rem_back   = (idx_reg != ZERO_S) &&
                     ((idx_reg == n_s - ONE_S) || (idx_reg > half_s));
        front_side = 1'b0;
        dst0       = ZERO_S;
        m0         = ZERO_S;
        step_dn0   = 1'b0;
        case (kind)
            KIND_INS:
            begin
                if (ins_back)
                begin
                    dst0     = n_s;
                    m0       = n_s - ipos;
                    step_dn0 = 1'b1;
                end
                else
                begin
                    front_side = 1'b1;
                    dst0       = MINUS1_S;
                    m0         = ipos;
                end
            end
            KIND_REM:
            begin
                dst0 = idx_reg;
                if (rem_back)
                begin
                    m0 = n_s - ONE_S - idx_reg;
                end
                else
                begin
                    front_side = 1'b1;
                    m0         = idx_reg;
                    step_dn0   = 1'b1;
                end
            end
            default:
            begin
                front_side = 1'b0;
            end
        endcase
        fin_addr = (kind == KIND_INS) ?
                   phys(front_reg, front_side ? (ipos - ONE_S) : ipos) :
                   phys(front_reg, idx_reg);
    end

    // Shift engine: read the source, write it to the destination in the next cycle
    always_comb
    begin
        src_pos      = step_dn_reg ? (dst_reg - ONE_S) : (dst_reg + ONE_S);
        dst_next     = dst_reg;
        cnt_next     = cnt_reg;
        step_dn_next = step_dn_reg;
        wr_pend_next = wr_pend_reg;
        if (ctl.load)
        begin
            dst_next     = dst0;
            cnt_next     = m0[CW-1:0];
            step_dn_next = step_dn0;
            wr_pend_next = 1'b0;
        end
        else if (ctl.step)
        begin
            wr_pend_next = (cnt_reg != '0);
            if (cnt_reg != '0)
            begin
                dst_next = src_pos;
                cnt_next = cnt_reg - CW'(1);
            end
        end
    end

    // Memory address and write selection
    always_comb
    begin
        ram_raddr = '0;
        ram_we    = 1'b0;
        ram_waddr = wr_addr_reg;
        ram_wdata = ram_rdata;
        if (ctl.look && in_rng)
        begin
            ram_raddr = phys(front_reg, idx_reg);
        end
        else if (ctl.step && (cnt_reg != '0))
        begin
            ram_raddr = phys(front_reg, src_pos);
        end
        if (ctl.step && wr_pend_reg)
        begin
            ram_we = 1'b1;
        end
        else if (ctl.fin && (kind == KIND_SET || kind == KIND_INS))
        begin
            ram_we    = 1'b1;
            ram_waddr = fin_addr;
            ram_wdata = val_reg;
        end
    end

    // Commit count and front pointer
    always_comb
    begin
        count_next = count_reg;
        front_next = front_reg;
        if (ctl.fin)
        begin
            if (kind == KIND_INS)
            begin
                count_next = count_reg + CW'(1);
                if (front_side)
                begin
                    front_next = phys(front_reg, MINUS1_S);
                end
            end
            else if (kind == KIND_REM)
            begin
                count_next = count_reg - CW'(1);
                if (count_reg == CW'(1))
                begin
                    front_next = '0;
                end
                else if (front_side)
                begin
                    front_next = phys(front_reg, ONE_S);
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            front_reg   <= '0;
            cnt_reg     <= '0;
            step_dn_reg <= 1'b0;
            wr_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            front_reg   <= front_next;
            cnt_reg     <= cnt_next;
            step_dn_reg <= step_dn_next;
            wr_pend_reg <= wr_pend_next;
            done_reg    <= ctl.fin;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg <= cmd;
            idx_reg <= $signed(index);
            val_reg <= value;
        end
        if (ctl.load)
        begin
            old_reg <= ram_rdata;
        end
        if (ctl.step && (cnt_reg != '0))
        begin
            wr_addr_reg <= phys(front_reg, dst_reg);
        end
        dst_reg <= dst_next;
        if (ctl.fin)
        begin
            status_reg   <= (kind == KIND_ERR) ? err_code : STS_OK;
            data_out_reg <= (kind == KIND_GET || kind == KIND_SET || kind == KIND_REM) ?
                            old_reg : '0;
        end
    end

    assign sts.mv_done = (cnt_reg == '0);
    assign done        = done_reg;
    assign data_out    = data_out_reg;
    assign status      = status_reg;
    assign count       = count_reg;

    `CID_ASSERT_NEVER(a_count_bound, count_reg > CW'(DEPTH), "entry count above capacity")
    `CID_ASSERT(a_empty_front, (count_reg == '0) |-> (front_reg == '0), "empty store with front pointer off zero")
    `CID_ASSERT(a_count_on_fin, !ctl.fin |=> $stable(count_reg), "entry count changed outside finish")
    `CID_ASSERT(a_done_after_fin, done_reg |-> $past(ctl.fin), "result strobe without a finish")

endmodule

`default_nettype wire

// File: src/circular_indexed_deque.sv
// Circular indexed deque: a ring of DEPTH values addressed by logical position,
// taking get, set, insert and remove requests. A request is accepted at a rising
// edge with start high and busy low; its result appears on data_out, status and
// count, marked by done high for exactly one cycle, and cannot be held off by the
// receiver. A request shifts M entries toward the nearer end, one slot per
// cycle through the store's single read and single write port, where M is zero
// for get, set, errors and inserts or removes at either end, and at most about
// count/2 otherwise. No clearing pass is needed after reset.
// Depends on cid_pkg, cid_ctrl, cid_datapath and cid_ram.
`default_nettype none

module circular_indexed_deque #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 cmd,
    input  logic [$clog2(DEPTH+1):0]   index,
    input  logic [VALUE_WIDTH-1:0]     value,
    output logic                       done,
    output logic [VALUE_WIDTH-1:0]     data_out,
    output logic [1:0]                 status,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    import cid_pkg::*;

    ctl_t ctl;
    sts_t sts;

    // Sequence each request
    cid_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    // Hold the ring, shift entries and post results
    cid_datapath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .sts      (sts),
        .cmd      (cmd),
        .index    (index),
        .value    (value),
        .done     (done),
        .data_out (data_out),
        .status   (status),
        .count    (count)
    );

endmodule

`default_nettype wire
